// ===== rtl/core/line_sensor_pid_steering_unit_defines.svh =====
// ----------------------------------------------------------------------------
// line_sensor_pid_steering_unit_defines
// Assertion macros shared by the steering unit RTL. Each macro expects the
// signals clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_PID_STEERING_UNIT_DEFINES_SVH
`define LINE_SENSOR_PID_STEERING_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define LSPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define LSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lsps_pkg.sv =====
// ----------------------------------------------------------------------------
// lsps_pkg
// Types, widths, codes and the sensor weight function of the steering unit.
// ----------------------------------------------------------------------------
package lsps_pkg;

	// Sensor input
	localparam int IN_W             = 8;
	localparam int SENSOR_COUNT_DEF = 8;

	// Widths sized for the whole SENSOR_COUNT range 2..16 on an 8-bit mask:
	// |weight sum| <= 36, count <= 8, |error| <= 8.
	localparam int SUM_W  = 7;
	localparam int MAG_W  = 6;
	localparam int CNT_W  = 4;
	localparam int E_W    = 5;
	localparam int LERR_W = 4;
	localparam int DE_W   = E_W + 1;

	// Configuration and arithmetic
	localparam int GAIN_W     = 32;
	localparam int OLIM_W     = 31;
	localparam int ILIM_W     = 16;
	localparam int ES_W       = 18;
	localparam int MB_W       = 18;
	localparam int PROD_W     = GAIN_W + MB_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int OUT_DATA_W = 40;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OLIM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ILIM = 3'd4;

	// Multiplier operand selection
	localparam logic [1:0] MUL_P = 2'd0;
	localparam logic [1:0] MUL_I = 2'd1;
	localparam logic [1:0] MUL_D = 2'd2;

	// Accumulator operations
	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
		logic [OLIM_W-1:0]        olimit;
		logic [ILIM_W-1:0]        ilimit;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       clear;
		logic       div_step;
		logic       integ;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic [1:0] acc_op;
		logic       finish;
	} cmd_t;

	// Weight of sensor idx: negative below the middle, positive above, no zero.
	function automatic logic signed [SUM_W-1:0] sensor_weight(input int idx, input int count);
		int half;
		int w;
		half = count >> 1;
		w    = (idx < half) ? (idx - half) : (idx - half + 1);
		return SUM_W'(w);
	endfunction

endpackage

// ===== rtl/core/lsps_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsps_ctrl
// Sequencer of the steering unit: input handshake, divide, PID steps and the
// output slot valid flag.
// ----------------------------------------------------------------------------
`include "line_sensor_pid_steering_unit_defines.svh"

module lsps_ctrl
	import lsps_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_op,
	output logic in_ready,
	input  logic out_ready,
	output logic out_valid,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_INTEG = 3'd2;
	localparam logic [2:0] ST_MUL_P = 3'd3;
	localparam logic [2:0] ST_MUL_I = 3'd4;
	localparam logic [2:0] ST_MUL_D = 3'd5;
	localparam logic [2:0] ST_ACC   = 3'd6;
	localparam logic [2:0] ST_SAT   = 3'd7;

	localparam int DIV_CNT_W = $clog2(MAG_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MAG_W - 1);

	logic [2:0]           state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
	logic                 out_valid_q;
	logic                 slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		div_cnt_d = div_cnt_q;
		cmd       = '0;
		cmd.mul_sel = MUL_P;
		cmd.acc_op  = ACC_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_op) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.load  = 1'b1;
						div_cnt_d = '0;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				div_cnt_d    = div_cnt_q + DIV_CNT_W'(1);
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_INTEG;
				end
			end
			ST_INTEG: begin
				cmd.integ = 1'b1;
				state_d   = ST_MUL_P;
			end
			ST_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_P;
				state_d     = ST_MUL_I;
			end
			ST_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_I;
				cmd.acc_op  = ACC_LOAD;
				state_d     = ST_MUL_D;
			end
			ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_D;
				cmd.acc_op  = ACC_ADD;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_SAT;
			end
			ST_SAT: begin
				// hold until the output slot can take the result
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			div_cnt_q <= div_cnt_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`LSPS_ASSERT(a_finish_slot_free, cmd.finish |-> slot_free, "result written over a waiting one")
	`LSPS_ASSERT_NEXT(a_busy_after_sample, in_valid && in_ready && !in_op, !in_ready, "sample not started")
	`LSPS_ASSERT(a_out_from_finish, $rose(out_valid_q) |-> $past(cmd.finish), "result without finish")
	`LSPS_ASSERT(a_div_cnt_range, (state_q == ST_DIV) |-> (div_cnt_q <= DIV_LAST), "divide overrun")

endmodule

// ===== rtl/core/lsps_dp.sv =====
// ----------------------------------------------------------------------------
// lsps_dp
// Datapath: weight sum, bit-serial divide, integral clamp, shared multiplier,
// accumulator, output saturation and result registers.
// ----------------------------------------------------------------------------
module lsps_dp
	import lsps_pkg::*;
#(
	parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
)
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  cmd_t                     cmd,
	input  logic [IN_W-1:0]          sensor_bits,
	output logic signed [GAIN_W-1:0] control_out,
	output logic signed [LERR_W-1:0] line_error,
	output logic                     out_clamped
);

	logic signed [SUM_W-1:0]  sum_c, neg_sum_c;
	logic [CNT_W-1:0]         cnt_c;
	logic [MAG_W-1:0]         mag_q;
	logic                     neg_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         rem_q, rem_sh;
	logic [MAG_W-1:0]         quo_q;
	logic signed [E_W-1:0]    q_mag, e_c, e_q, last_q;
	logic signed [ES_W-1:0]   es_q, es_next;
	logic signed [ES_W:0]     es_sum, lim_pos, lim_neg;
	logic signed [DE_W-1:0]   de;
	logic signed [GAIN_W-1:0] mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  prod_ext, acc_q;
	logic signed [ACC_W-1:0]  olim_pos, olim_neg;

	// Weight sum and count of the set sensors
	always_comb begin
		sum_c = '0;
		cnt_c = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (i < SENSOR_COUNT && sensor_bits[i]) begin
				sum_c = sum_c + sensor_weight(i, SENSOR_COUNT);
				cnt_c = cnt_c + CNT_W'(1);
			end
		end
		neg_sum_c = -sum_c;
	end

	assign rem_sh = {rem_q[CNT_W-2:0], mag_q[MAG_W-1]};
	assign q_mag  = {1'b0, quo_q[E_W-2:0]};
	assign e_c    = neg_q ? -q_mag : q_mag;

	// Integral update with clamp to +/- integral limit
	always_comb begin
		es_sum  = {es_q[ES_W-1], es_q} + {{(ES_W + 1 - E_W){e_c[E_W-1]}}, e_c};
		lim_pos = {{(ES_W + 1 - ILIM_W){1'b0}}, cfg.ilimit};
		lim_neg = -lim_pos;
		if (es_sum > lim_pos) begin
			es_next = lim_pos[ES_W-1:0];
		end else if (es_sum < lim_neg) begin
			es_next = lim_neg[ES_W-1:0];
		end else begin
			es_next = es_sum[ES_W-1:0];
		end
	end

	assign de = {e_q[E_W-1], e_q} - {last_q[E_W-1], last_q};

	// Shared multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MUL_P: begin
				mul_a = cfg.kp;
				mul_b = {{(MB_W - E_W){e_q[E_W-1]}}, e_q};
			end
			MUL_I: begin
				mul_a = cfg.ki;
				mul_b = es_q;
			end
			MUL_D: begin
				mul_a = cfg.kd;
				mul_b = {{(MB_W - DE_W){de[DE_W-1]}}, de};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_ext = {{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign olim_pos = {{(ACC_W - OLIM_W){1'b0}}, cfg.olimit};
	assign olim_neg = -olim_pos;

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q   <= sum_c[SUM_W-1] ? neg_sum_c[MAG_W-1:0] : sum_c[MAG_W-1:0];
			neg_q   <= sum_c[SUM_W-1];
			// an empty mask divides zero by one
			count_q <= (cnt_c == '0) ? CNT_W'(1) : cnt_c;
			rem_q   <= '0;
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
			if (rem_sh >= count_q) begin
				rem_q <= rem_sh - count_q;
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
		if (cmd.integ) begin
			e_q <= e_c;
		end
		if (cmd.mul_en) begin
			prod_s1 <= mul_a * mul_b;
		end
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= prod_ext;
			ACC_ADD:  acc_q <= acc_q + prod_ext;
			default:  acc_q <= acc_q;
		endcase
		if (cmd.finish) begin
			line_error <= e_q[LERR_W-1:0];
			if (acc_q > olim_pos) begin
				control_out <= olim_pos[GAIN_W-1:0];
				out_clamped <= 1'b1;
			end else if (acc_q < olim_neg) begin
				control_out <= olim_neg[GAIN_W-1:0];
				out_clamped <= 1'b1;
			end else begin
				control_out <= acc_q[GAIN_W-1:0];
				out_clamped <= 1'b0;
			end
		end
	end

	// Loop state: integral sum and previous error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			es_q   <= '0;
			last_q <= '0;
		end else if (cmd.clear) begin
			es_q   <= '0;
			last_q <= '0;
		end else begin
			if (cmd.integ) begin
				es_q <= es_next;
			end
			if (cmd.finish) begin
				last_q <= e_q;
			end
		end
	end

endmodule

// ===== rtl/core/line_sensor_pid_steering_unit.sv =====
// ----------------------------------------------------------------------------
// line_sensor_pid_steering_unit
// Steering PID controller driven by a line-sensor mask.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transaction per sample; s_tuser = 0 processes the
//   sensor mask in s_tdata, s_tuser = 1 clears the integral sum and the
//   previous error and produces no result.
//   Output stream (m_*): one transaction per sample with the saturated drive
//   value, the position error used and a flag set when the output limit cut.
//   Configuration: write cfg_data to register cfg_index while cfg_we is high;
//   0 kp, 1 ki, 2 kd, 3 output limit, 4 integral limit; other indexes drop.
//   Sequence: a sample is accepted only while idle, then runs the bit-serial
//   divide, the integral update, three passes through the single shared
//   multiplier, an accumulate step and a saturate step. The sequencer handles
//   one sample at a time, so a new sample is taken once the last is finished.
//   Reset: all gains and limits, the integral sum and the previous error go
//   to zero, and both streams come up empty.
//   Stall: the finished result waits in the output register; the next sample
//   is already accepted and computed, and holds at its last step until the
//   output register has been taken.
// ----------------------------------------------------------------------------
module line_sensor_pid_steering_unit
	import lsps_pkg::*;
#(
	parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // [7:0] sensor_bits
	input  logic                  s_tuser,   // [0] op
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] control_out, [35:32] line_error, zero pad
	output logic                  m_tuser,   // [0] out_clamped
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                     cfg_q;
	cmd_t                     cmd;
	logic signed [GAIN_W-1:0] control_out;
	logic signed [LERR_W-1:0] line_error;
	logic                     out_clamped;

	// Configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP:   cfg_q.kp     <= cfg_data[GAIN_W-1:0];
				REG_KI:   cfg_q.ki     <= cfg_data[GAIN_W-1:0];
				REG_KD:   cfg_q.kd     <= cfg_data[GAIN_W-1:0];
				REG_OLIM: cfg_q.olimit <= cfg_data[OLIM_W-1:0];
				REG_ILIM: cfg_q.ilimit <= cfg_data[ILIM_W-1:0];
				default:  cfg_q        <= cfg_q;
			endcase
		end
	end

	// Sequencer: handshakes and step commands
	lsps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_op     (s_tuser),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd)
	);

	// Arithmetic and result registers
	lsps_dp #(
		.SENSOR_COUNT (SENSOR_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.sensor_bits (s_tdata),
		.control_out (control_out),
		.line_error  (line_error),
		.out_clamped (out_clamped)
	);

	// Pack the result fields, lowest field first, zero fill to whole bytes
	assign m_tdata = {{(OUT_DATA_W - GAIN_W - LERR_W){1'b0}}, line_error, control_out};
	assign m_tuser = out_clamped;

endmodule

// ===== tb/tb_line_sensor_pid_steering_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_sensor_pid_steering_unit
// Self-checking bench for the line-sensor PID steering unit. A behavioral
// PID model runs beside the block and predicts every output transaction;
// directed tests cover the sensor error table, the integral clamp, output
// saturation and the clear command, then randomized blocks sweep gain and
// limit settings under changing stream back-pressure.
// ----------------------------------------------------------------------------
module tb_line_sensor_pid_steering_unit;
	import lsps_pkg::*;

	localparam int SENSORS        = SENSOR_COUNT_DEF;
	localparam int SETTLE_CYCLES  = 24;    // settle time after the last expected result
	localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction on either stream
	localparam int RAND_BLOCKS    = 12;
	localparam int BLOCK_ITEMS    = 71;

	// Command codes carried on s_tuser
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// Register indexes the block must drop
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_ILIM + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

	typedef struct packed {
		logic [31:0] control_out;
		logic [3:0]  line_error;
		logic        out_clamped;
	} steer_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Steering model state and register copy
	cfg_t          gains;
	int            integ_sum;
	int            model_last_err;
	steer_result_t expected_drive[$];

	int snd_idle_pct;
	int rcv_idle_pct;
	int fail_count;
	int quiet_cycles;

	line_sensor_pid_steering_unit #(
		.SENSOR_COUNT(SENSORS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Model: one PID step on a sensor mask, updates integ_sum/model_last_err
	// ------------------------------------------------------------------
	function automatic steer_result_t pid_step(input logic [IN_W-1:0] mask);
		int            wsum;
		int            hits;
		int            err;
		longint        drive;
		longint        bound;
		steer_result_t r;
		wsum = 0;
		hits = 0;
		for (int i = 0; i < SENSORS && i < IN_W; i++) begin
			if (mask[i]) begin
				wsum += (i < SENSORS / 2) ? i - SENSORS / 2 : i - SENSORS / 2 + 1;
				hits++;
			end
		end
		// integer division truncates toward zero, as the position error requires
		err = (hits == 0) ? 0 : wsum / hits;

		integ_sum += err;
		if (integ_sum > int'(gains.ilimit))
			integ_sum = int'(gains.ilimit);
		if (integ_sum < -int'(gains.ilimit))
			integ_sum = -int'(gains.ilimit);

		drive = longint'(gains.kp) * err + longint'(gains.ki) * integ_sum
			+ longint'(gains.kd) * (err - model_last_err);
		bound = longint'(gains.olimit);
		r.out_clamped = 1'b0;
		if (drive > bound) begin
			drive = bound;
			r.out_clamped = 1'b1;
		end
		if (drive < -bound) begin
			drive = -bound;
			r.out_clamped = 1'b1;
		end
		model_last_err = err;
		r.control_out  = drive[31:0];
		r.line_error   = err[3:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Input stream driver: one transaction, valid left high afterwards
	// ------------------------------------------------------------------
	task automatic send_item(input logic op, input logic [IN_W-1:0] mask);
		if ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= mask;
		do @(posedge clk); while (!s_tready);
		if (op == OP_CLEAR) begin
			integ_sum      = 0;
			model_last_err = 0;
		end else begin
			expected_drive.push_back(pid_step(mask));
		end
	endtask

	// Hold the input until every pending result is out, then let a clear settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_drive.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all five registers, then poke one undecoded index with junk.
	task automatic program_regs(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
		input logic [CFG_DATA_W-1:0] kd, input logic [CFG_DATA_W-1:0] olim,
		input logic [CFG_DATA_W-1:0] ilim);
		logic [CFG_IDX_W-1:0]  idx [5];
		logic [CFG_DATA_W-1:0] word [5];
		wait_idle();
		idx  = '{REG_KP, REG_KI, REG_KD, REG_OLIM, REG_ILIM};
		word = '{kp, ki, kd, olim, ilim};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= word[i];
			@(posedge clk);
		end
		cfg_index <= CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST));
		cfg_data  <= $urandom();
		@(posedge clk);
		cfg_we <= 1'b0;
		gains.kp     = kp;
		gains.ki     = ki;
		gains.kd     = kd;
		gains.olimit = olim[OLIM_W-1:0];
		gains.ilimit = ilim[ILIM_W-1:0];
	endtask

	task automatic set_idling(input int snd_pct, input int rcv_pct);
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
	endtask

	// ------------------------------------------------------------------
	// Random value pickers, biased toward the extremes
	// ------------------------------------------------------------------
	function automatic logic [IN_W-1:0] pick_mask();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return IN_W'(1) << $urandom_range(IN_W - 1);
			3, 4:    return IN_W'(3) << $urandom_range(IN_W - 2);
			5:       return IN_W'(7) << $urandom_range(IN_W - 3);
			default: return IN_W'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		logic [31:0] mag;
		mag = $urandom_range(32'h0008_0000);
		case ($urandom_range(7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '0;
			3, 4:    return $urandom_range(1) ? mag : -mag;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_olim();
		case ($urandom_range(5))
			0:       return {1'($urandom_range(1)), 31'h0};
			1:       return {1'($urandom_range(1)), 31'h7FFF_FFFF};
			2, 3:    return {1'($urandom_range(1)), 31'($urandom_range(32'h0040_0000))};
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_ilim();
		case ($urandom_range(5))
			0:       return {16'($urandom()), 16'h0};
			1:       return {16'($urandom()), 16'hFFFF};
			2, 3, 4: return {16'($urandom()), 16'($urandom_range(40, 1))};
			default: return $urandom();
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// All gains reset to zero: any sample gives a zero, unclamped drive.
	task automatic test_reset_values();
		send_item(OP_SAMPLE, 8'h80);
	endtask

	// A kp of 2^16 exposes the averaged position error directly, including truncation.
	task automatic test_position_error();
		logic [IN_W-1:0] masks [10];
		masks = '{8'h00, 8'h01, 8'h80, 8'hFF, 8'h03, 8'h07, 8'h0E, 8'h70, 8'hC0, 8'h18};
		program_regs(32'h0001_0000, '0, '0, 32'h7FFF_FFFF, '0);
		foreach (masks[i])
			send_item(OP_SAMPLE, masks[i]);
	endtask

	// Drive the error sum into both bounds, then lower and zero the bound.
	task automatic test_integral_clamp();
		program_regs('0, 32'h0001_0000, '0, 32'h7FFF_FFFF, 32'd6);
		send_item(OP_SAMPLE, 8'h80);
		send_item(OP_SAMPLE, 8'h80);
		repeat (4) send_item(OP_SAMPLE, 8'h01);
		program_regs('0, 32'h0001_0000, '0, 32'h7FFF_FFFF, 32'hABCD_0002);
		send_item(OP_SAMPLE, 8'h00);
		program_regs('0, 32'h0001_0000, '0, 32'h7FFF_FFFF, '0);
		send_item(OP_SAMPLE, 8'h80);
	endtask

	// Extreme gains against a zero and then a full-scale output bound.
	task automatic test_output_limit();
		program_regs(32'h7FFF_FFFF, '0, 32'h8000_0000, 32'h8000_0000, '0);
		send_item(OP_SAMPLE, 8'h80);
		send_item(OP_SAMPLE, 8'h00);
		program_regs(32'h7FFF_FFFF, '0, 32'h8000_0000, 32'hFFFF_FFFF, '0);
		send_item(OP_SAMPLE, 8'h80);
		send_item(OP_SAMPLE, 8'h01);
	endtask

	// A clear drops the error sum and the previous error.
	task automatic test_clear_state();
		program_regs('0, 32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'd10);
		send_item(OP_SAMPLE, 8'h80);
		send_item(OP_CLEAR, IN_W'($urandom()));
		send_item(OP_SAMPLE, 8'h80);
	endtask

	// Randomized blocks, each with fresh register settings.
	task automatic test_random_blocks();
		for (int b = 0; b < RAND_BLOCKS; b++) begin
			program_regs(pick_gain(), pick_gain(), pick_gain(), pick_olim(), pick_ilim());
			if (b < RAND_BLOCKS / 3)
				set_idling(34, 57);
			else if (b < 2 * RAND_BLOCKS / 3)
				set_idling(57, 34);
			else
				set_idling(0, 0);
			for (int n = 0; n < BLOCK_ITEMS; n++) begin
				if ($urandom_range(99) < 6)
					send_item(OP_CLEAR, IN_W'($urandom()));
				else
					send_item(OP_SAMPLE, pick_mask());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Output stream: random back-pressure and result checking
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		steer_result_t want;
		if (m_tvalid && m_tready) begin
			if (expected_drive.size() == 0) begin
				fail_count++;
				$display("%0t ns: unexpected result, expected none, got control_out %h",
					$time, m_tdata[31:0]);
			end else begin
				want = expected_drive.pop_front();
				if (m_tdata[31:0] !== want.control_out) begin
					fail_count++;
					$display("%0t ns: control_out expected %h got %h",
						$time, want.control_out, m_tdata[31:0]);
				end
				if (m_tdata[35:32] !== want.line_error) begin
					fail_count++;
					$display("%0t ns: line_error expected %h got %h",
						$time, want.line_error, m_tdata[35:32]);
				end
				if (m_tuser !== want.out_clamped) begin
					fail_count++;
					$display("%0t ns: out_clamped expected %b got %b",
						$time, want.out_clamped, m_tuser);
				end
			end
		end
	end

	// Watchdog: end the run when neither stream moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_line_sensor_pid_steering_unit: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = OP_SAMPLE;
		m_tready       = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_KP;
		cfg_data       = '0;
		gains          = '0;
		integ_sum      = 0;
		model_last_err = 0;
		fail_count     = 0;
		quiet_cycles   = 0;
		set_idling(34, 57);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_position_error();
		test_integral_clamp();
		test_output_limit();
		test_clear_state();
		test_random_blocks();

		wait_idle();
		if (fail_count == 0)
			$display("tb_line_sensor_pid_steering_unit: clean");
		else
			$display("tb_line_sensor_pid_steering_unit: errors");
		$finish;
	end

endmodule
